/* src/ole_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_pkg
// Shared types, sizes and codes for the ordered list engine.
// ----------------------------------------------------------------------------
package ole_pkg;

  localparam int unsigned DEPTH  = 32;
  localparam int unsigned IDX_W  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(DEPTH + 1);
  localparam int unsigned POS_W  = 5;
  // compare width: holds a count, a position field and one more for +1/+2
  localparam int unsigned PW     = (CNT_W > POS_W) ? CNT_W : POS_W;
  localparam int unsigned CW     = PW + 1;
  localparam int unsigned VAL_W  = 32;
  localparam int unsigned OCNT_W = 6;
  localparam int unsigned RES_CAP = 32;

  typedef enum logic [2:0] {
    ACT_APPEND   = 3'd0,
    ACT_DELETE   = 3'd1,
    ACT_COUNT    = 3'd2,
    ACT_DUMP_ALL = 3'd3,
    ACT_DUMP_ALT = 3'd4
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2,
    ST_RANGE = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD   = 2'd0,
    CELL_APPEND = 2'd1,
    CELL_DELETE = 2'd2,
    CELL_ROTATE = 2'd3
  } cell_op_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_DUMP = 1'b1
  } state_e;

  typedef struct packed {
    cell_op_e                op;
    logic [PW-1:0]           idx;
    logic [CNT_W-1:0]        count;
    logic signed [VAL_W-1:0] value;
  } cell_cmd_t;

  function automatic logic [OCNT_W-1:0] cnt_out(input logic [CNT_W-1:0] c);
    logic [CNT_W+OCNT_W-1:0] tmp;
    tmp = {{OCNT_W{1'b0}}, c};
    return tmp[OCNT_W-1:0];
  endfunction

  function automatic logic [POS_W-1:0] pos_out(input logic [IDX_W-1:0] p);
    logic [IDX_W+POS_W-1:0] tmp;
    tmp = {{POS_W{1'b0}}, p};
    return tmp[POS_W-1:0];
  endfunction

endpackage

/* src/ole_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_in_if / ole_out_if
// Valid/ready channels for command beats and result beats.
// ----------------------------------------------------------------------------
interface ole_in_if;
  logic                               valid;
  logic                               ready;
  logic [2:0]                         action;
  logic signed [ole_pkg::VAL_W-1:0]   item_value;
  logic [ole_pkg::POS_W-1:0]          position_in;

  modport source (output valid, action, item_value, position_in, input ready);
  modport sink   (input valid, action, item_value, position_in, output ready);
endinterface

interface ole_out_if;
  logic                               valid;
  logic                               ready;
  logic [1:0]                         status;
  logic                               has_value;
  logic signed [ole_pkg::VAL_W-1:0]   value_out;
  logic [ole_pkg::POS_W-1:0]          position_out;
  logic [ole_pkg::OCNT_W-1:0]         total_nodes;
  logic [ole_pkg::OCNT_W-1:0]         even_nodes;
  logic [ole_pkg::OCNT_W-1:0]         odd_nodes;
  logic                               last;

  modport source (output valid, status, has_value, value_out, position_out,
                         total_nodes, even_nodes, odd_nodes, last,
                  input ready);
  modport sink   (input valid, status, has_value, value_out, position_out,
                        total_nodes, even_nodes, odd_nodes, last,
                  output ready);
endinterface

/* src/ole_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_cell
// One list slot: loads on append, pulls from its neighbor on delete/rotate, or from the head as the rotate tail.
// ----------------------------------------------------------------------------
module ole_cell (
  input  logic                              clk_i,
  input  logic [ole_pkg::IDX_W-1:0]         cell_idx_i,
  input  ole_pkg::cell_cmd_t                cmd_i,
  input  logic signed [ole_pkg::VAL_W-1:0]  next_i,
  input  logic signed [ole_pkg::VAL_W-1:0]  head_i,
  output logic signed [ole_pkg::VAL_W-1:0]  value_o,
  output logic                              hit_odd_o
);

  logic signed [ole_pkg::VAL_W-1:0] value_q, value_d;
  logic [ole_pkg::CW-1:0] my_ext, my_p1, cnt_ext, sel_ext;

  assign my_ext  = {{(ole_pkg::CW - ole_pkg::IDX_W){1'b0}}, cell_idx_i};
  assign my_p1   = my_ext + 1'b1;
  assign cnt_ext = {{(ole_pkg::CW - ole_pkg::CNT_W){1'b0}}, cmd_i.count};
  assign sel_ext = {1'b0, cmd_i.idx};

  always_comb begin
    value_d = value_q;
    case (cmd_i.op)
      ole_pkg::CELL_APPEND: begin
        if (my_ext == cnt_ext) value_d = cmd_i.value;
      end
      ole_pkg::CELL_DELETE: begin
        if (my_ext >= sel_ext && my_p1 < cnt_ext) value_d = next_i;
      end
      ole_pkg::CELL_ROTATE: begin
        // occupied prefix turns by one: tail slot takes the old head
        if (my_p1 < cnt_ext) value_d = next_i;
        else if (my_p1 == cnt_ext) value_d = head_i;
      end
      default: value_d = value_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o   = value_q;
  assign hit_odd_o = (my_ext == sel_ext) & value_q[0];

endmodule

/* src/ole_chain.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ole_chain
// Row of list cells; cell 0 is the head of the list.
// ----------------------------------------------------------------------------
module ole_chain (
  input  logic                              clk_i,
  input  ole_pkg::cell_cmd_t                cmd_i,
  output logic signed [ole_pkg::VAL_W-1:0]  head_o,
  output logic                              sel_odd_o
);

  logic signed [ole_pkg::VAL_W-1:0] vals [ole_pkg::DEPTH];
  logic signed [ole_pkg::VAL_W-1:0] nexts [ole_pkg::DEPTH];
  logic [ole_pkg::DEPTH-1:0] hits;

  for (genvar g = 0; g < ole_pkg::DEPTH; g++) begin : g_cell
    if (g == ole_pkg::DEPTH - 1) begin : g_tail
      assign nexts[g] = '0;
    end else begin : g_mid
      assign nexts[g] = vals[g+1];
    end

    ole_cell u_cell (
      .clk_i      (clk_i),
      .cell_idx_i (ole_pkg::IDX_W'(g)),
      .cmd_i      (cmd_i),
      .next_i     (nexts[g]),
      .head_i     (vals[0]),
      .value_o    (vals[g]),
      .hit_odd_o  (hits[g])
    );
  end

  assign head_o    = vals[0];
  assign sel_odd_o = |hits;

endmodule

/* src/ordered_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_engine
// Ordered list of signed 32-bit values with append, delete and dumps.
// ----------------------------------------------------------------------------
// Append, delete, count report and unknown actions each give one result beat.
// A dump turns the occupied part of the cell chain by one slot per cycle
// (unless a result beat is held by an output stall), reading each node at
// the head. Once it is taken, it holds off new commands until every node has
// passed the head. The list is back in order when the dump ends. A dump of an
// empty list, or an alternate dump of a single node, gives one result beat
// like the other actions and turns nothing. A new command is taken once the
// dump is done and the result register is free or being drained. Dump-all
// shows at most 32 nodes.
module ordered_list_engine (
  input  logic   clk_i,
  input  logic   rst_ni,
  ole_in_if.sink   in_i,
  ole_out_if.source out_o
);

  ole_pkg::state_e state_q, state_d;
  logic [ole_pkg::CNT_W-1:0] count_q, count_d, even_q, even_d, odd_q, odd_d;
  logic [ole_pkg::IDX_W-1:0] k_q, k_d;
  logic [ole_pkg::OCNT_W-1:0] n_q, n_d;
  logic alt_q, alt_d;

  logic ov_q, ov_d;
  ole_pkg::status_e st_q, st_d;
  logic hv_q, hv_d, last_q, last_d;
  logic signed [ole_pkg::VAL_W-1:0] val_q, val_d;
  logic [ole_pkg::POS_W-1:0] pos_q, pos_d;

  ole_pkg::cell_cmd_t cmd;
  logic signed [ole_pkg::VAL_W-1:0] head;
  logic sel_odd;

  logic slot_free, accept, need_emit, is_last, step_done;
  logic [ole_pkg::CW-1:0] k_ext, cnt_ext, pin_ext;

  ole_chain u_chain (
    .clk_i     (clk_i),
    .cmd_i     (cmd),
    .head_o    (head),
    .sel_odd_o (sel_odd)
  );

  assign slot_free = !ov_q || out_o.ready;
  assign in_i.ready = (state_q == ole_pkg::S_IDLE) && slot_free;
  assign accept = in_i.valid && in_i.ready;

  assign k_ext   = {{(ole_pkg::CW - ole_pkg::IDX_W){1'b0}}, k_q};
  assign cnt_ext = {{(ole_pkg::CW - ole_pkg::CNT_W){1'b0}}, count_q};
  assign pin_ext = {{(ole_pkg::CW - ole_pkg::POS_W){1'b0}}, in_i.position_in};

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    even_d  = even_q;
    odd_d   = odd_q;
    k_d     = k_q;
    n_d     = n_q;
    alt_d   = alt_q;
    ov_d    = ov_q && !out_o.ready;
    st_d    = st_q;
    hv_d    = hv_q;
    last_d  = last_q;
    val_d   = val_q;
    pos_d   = pos_q;

    cmd.op    = ole_pkg::CELL_HOLD;
    cmd.idx   = pin_ext[ole_pkg::PW-1:0];
    cmd.count = count_q;
    cmd.value = in_i.item_value;

    need_emit = 1'b0;
    is_last   = 1'b0;
    step_done = 1'b0;

    unique case (state_q)
      ole_pkg::S_IDLE: begin
        if (accept) begin
          ov_d   = 1'b1;
          st_d   = ole_pkg::ST_OK;
          hv_d   = 1'b0;
          last_d = 1'b1;
          val_d  = '0;
          pos_d  = '0;
          unique case (in_i.action)
            ole_pkg::ACT_APPEND: begin
              if (cnt_ext == ole_pkg::CW'(ole_pkg::DEPTH)) begin
                st_d = ole_pkg::ST_FULL;
              end else begin
                cmd.op  = ole_pkg::CELL_APPEND;
                count_d = count_q + 1'b1;
                if (in_i.item_value[0]) odd_d = odd_q + 1'b1;
                else even_d = even_q + 1'b1;
              end
            end
            ole_pkg::ACT_DELETE: begin
              if (count_q == '0) begin
                st_d = ole_pkg::ST_EMPTY;
              end else if (pin_ext >= cnt_ext) begin
                st_d = ole_pkg::ST_RANGE;
              end else begin
                cmd.op  = ole_pkg::CELL_DELETE;
                count_d = count_q - 1'b1;
                if (sel_odd) odd_d = odd_q - 1'b1;
                else even_d = even_q - 1'b1;
              end
            end
            ole_pkg::ACT_DUMP_ALL, ole_pkg::ACT_DUMP_ALT: begin
              if (count_q == '0) begin
                st_d = ole_pkg::ST_EMPTY;
              end else if (in_i.action == ole_pkg::ACT_DUMP_ALT
                           && cnt_ext == ole_pkg::CW'(1)) begin
                st_d = ole_pkg::ST_OK;
              end else begin
                ov_d    = ov_q && !out_o.ready;
                state_d = ole_pkg::S_DUMP;
                k_d     = '0;
                n_d     = '0;
                alt_d   = (in_i.action == ole_pkg::ACT_DUMP_ALT);
              end
            end
            default: ;
          endcase
        end
      end
      ole_pkg::S_DUMP: begin
        if (alt_q) begin
          need_emit = k_q[0];
          is_last   = (k_ext + ole_pkg::CW'(2)) >= cnt_ext;
        end else begin
          need_emit = (n_q < ole_pkg::OCNT_W'(ole_pkg::RES_CAP));
          is_last   = ((k_ext + 1'b1) == cnt_ext)
                      || (n_q == ole_pkg::OCNT_W'(ole_pkg::RES_CAP - 1));
        end
        if (!need_emit || slot_free) begin
          cmd.op = ole_pkg::CELL_ROTATE;
          k_d    = k_q + 1'b1;
          if (need_emit) begin
            ov_d   = 1'b1;
            st_d   = ole_pkg::ST_OK;
            hv_d   = 1'b1;
            last_d = is_last;
            val_d  = head;
            pos_d  = ole_pkg::pos_out(k_q);
            n_d    = n_q + 1'b1;
          end
          step_done = ((k_ext + 1'b1) == cnt_ext);
          if (step_done) state_d = ole_pkg::S_IDLE;
        end
      end
      default: state_d = ole_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ole_pkg::S_IDLE;
      count_q <= '0;
      even_q  <= '0;
      odd_q   <= '0;
      k_q     <= '0;
      n_q     <= '0;
      alt_q   <= 1'b0;
      ov_q    <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      even_q  <= even_d;
      odd_q   <= odd_d;
      k_q     <= k_d;
      n_q     <= n_d;
      alt_q   <= alt_d;
      ov_q    <= ov_d;
    end
  end

  // result payload and the counts it carries
  logic [ole_pkg::OCNT_W-1:0] tot_q, ev_q, od_q;

  always_ff @(posedge clk_i) begin
    st_q   <= st_d;
    hv_q   <= hv_d;
    last_q <= last_d;
    val_q  <= val_d;
    pos_q  <= pos_d;
    tot_q  <= ole_pkg::cnt_out(count_d);
    ev_q   <= ole_pkg::cnt_out(even_d);
    od_q   <= ole_pkg::cnt_out(odd_d);
  end

  assign out_o.valid        = ov_q;
  assign out_o.status       = st_q;
  assign out_o.has_value    = hv_q;
  assign out_o.value_out    = val_q;
  assign out_o.position_out = pos_q;
  assign out_o.total_nodes  = tot_q;
  assign out_o.even_nodes   = ev_q;
  assign out_o.odd_nodes    = od_q;
  assign out_o.last         = last_q;

endmodule

/* bench/tb_ordered_list_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_ordered_list_engine
// Self-checking bench for the ordered list engine. Commands go in over a
// valid/ready channel and result beats come back over another. A scoreboard
// keeps its own copy of the list and queues the beats each accepted command
// should produce. Every returned beat is checked field by field. The
// stimulus is a short directed run, then random grow/shrink sequences under
// several source-idle and sink-stall mixes, plus one long sink hold-off.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine;

  typedef struct packed {
    logic [1:0]                       status;
    logic                             has_value;
    logic signed [ole_pkg::VAL_W-1:0] value;
    logic [ole_pkg::POS_W-1:0]        position;
    logic [ole_pkg::OCNT_W-1:0]       total;
    logic [ole_pkg::OCNT_W-1:0]       even;
    logic [ole_pkg::OCNT_W-1:0]       odd;
    logic                             last;
  } beat_t;

  class list_scoreboard;
    logic signed [ole_pkg::VAL_W-1:0] nodes[$];
    int unsigned                      n_even;
    int unsigned                      n_odd;
    beat_t                            pending[$];
    int                               errors;

    function int unsigned size();
      return nodes.size();
    endfunction

    task report(string what);
      errors++;
      $display("%0t ns: mismatch: %s", $time, what);
    endtask

    function void push(logic [1:0] st, logic hv, logic signed [ole_pkg::VAL_W-1:0] v,
                       int unsigned p, logic lst);
      beat_t b;
      b.status    = st;
      b.has_value = hv;
      b.value     = v;
      b.position  = ole_pkg::POS_W'(p);
      b.total     = ole_pkg::OCNT_W'(nodes.size());
      b.even      = ole_pkg::OCNT_W'(n_even);
      b.odd       = ole_pkg::OCNT_W'(n_odd);
      b.last      = lst;
      pending.push_back(b);
    endfunction

    function void push_dump(int unsigned first, int unsigned stride);
      int unsigned shown;
      shown = 0;
      if (nodes.size() == 0) begin
        push(ole_pkg::ST_EMPTY, 1'b0, '0, 0, 1'b1);
        return;
      end
      for (int unsigned i = first; i < nodes.size() && shown < ole_pkg::RES_CAP;
           i += stride) begin
        push(ole_pkg::ST_OK, 1'b1, nodes[i], i, 1'b0);
        shown++;
      end
      // alternate dump of a single node shows nothing
      if (shown == 0) push(ole_pkg::ST_OK, 1'b0, '0, 0, 1'b1);
      else pending[$].last = 1'b1;
    endfunction

    function void note_command(logic [2:0] act, logic signed [ole_pkg::VAL_W-1:0] v,
                               logic [ole_pkg::POS_W-1:0] p);
      logic [1:0] st;
      st = ole_pkg::ST_OK;
      case (act)
        ole_pkg::ACT_APPEND: begin
          if (nodes.size() >= ole_pkg::DEPTH) begin
            st = ole_pkg::ST_FULL;
          end else begin
            nodes.push_back(v);
            if (v[0]) n_odd++;
            else n_even++;
          end
        end
        ole_pkg::ACT_DELETE: begin
          if (nodes.size() == 0) begin
            st = ole_pkg::ST_EMPTY;
          end else if (p >= nodes.size()) begin
            st = ole_pkg::ST_RANGE;
          end else begin
            if (nodes[p][0]) n_odd--;
            else n_even--;
            nodes.delete(p);
          end
        end
        ole_pkg::ACT_DUMP_ALL: begin
          push_dump(0, 1);
          return;
        end
        ole_pkg::ACT_DUMP_ALT: begin
          push_dump(1, 2);
          return;
        end
        default: ;
      endcase
      push(st, 1'b0, '0, 0, 1'b1);
    endfunction

    task cmp(string name, logic [ole_pkg::VAL_W-1:0] got,
             logic [ole_pkg::VAL_W-1:0] want);
      if (got !== want) report($sformatf("%s got %0h expected %0h", name, got, want));
    endtask

    task check_beat(beat_t got);
      beat_t want;
      if (pending.size() == 0) begin
        report("result beat with nothing outstanding");
        return;
      end
      want = pending.pop_front();
      cmp("status", got.status, want.status);
      cmp("has_value", got.has_value, want.has_value);
      cmp("value_out", got.value, want.value);
      cmp("position_out", got.position, want.position);
      cmp("total_nodes", got.total, want.total);
      cmp("even_nodes", got.even, want.even);
      cmp("odd_nodes", got.odd, want.odd);
      cmp("last", got.last, want.last);
    endtask
  endclass

  logic clk;
  logic rst_n;
  int   src_idle;
  int   dst_stall;
  logic hold_go;
  logic rx_hold;
  logic growing;

  list_scoreboard sb = new;

  ole_in_if  in_if ();
  ole_out_if out_if ();

  ordered_list_engine i_dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("ordered_list_engine test failed");
    $finish;
  end

  // long sink hold-off so the engine backs up and stalls its input
  initial begin
    rx_hold = 1'b0;
    wait (hold_go === 1'b1);
    @(posedge clk);
    rx_hold = 1'b1;
    repeat (400) @(posedge clk);
    rx_hold = 1'b0;
  end

  // result sink: ready changes on the falling edge, beats sampled on the rising edge
  initial begin
    beat_t b;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      out_if.ready = !rx_hold && ($urandom_range(0, 99) >= dst_stall);
      @(posedge clk);
      if (rst_n && out_if.valid && out_if.ready) begin
        b.status    = out_if.status;
        b.has_value = out_if.has_value;
        b.value     = out_if.value_out;
        b.position  = out_if.position_out;
        b.total     = out_if.total_nodes;
        b.even      = out_if.even_nodes;
        b.odd       = out_if.odd_nodes;
        b.last      = out_if.last;
        sb.check_beat(b);
      end
    end
  end

  // called just after a falling edge; returns just after the next one following the beat
  task automatic send(logic [2:0] act, logic signed [ole_pkg::VAL_W-1:0] v,
                      logic [ole_pkg::POS_W-1:0] p);
    while ($urandom_range(0, 99) < src_idle) begin
      in_if.valid = 1'b0;
      @(negedge clk);
    end
    in_if.valid       = 1'b1;
    in_if.action      = act;
    in_if.item_value  = v;
    in_if.position_in = p;
    do @(posedge clk); while (!in_if.ready);
    sb.note_command(act, v, p);
    @(negedge clk);
  endtask

  function automatic logic signed [ole_pkg::VAL_W-1:0] pick_value();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return -32'sd1;
      3: return 32'sd0;
      default: return $urandom();
    endcase
  endfunction

  // grow toward full, then shrink toward empty, with reads mixed in
  task automatic random_run(int n);
    int          r;
    int unsigned cnt;
    logic [2:0]  act;
    logic [4:0]  p;
    for (int k = 0; k < n; k++) begin
      cnt = sb.size();
      if (cnt >= ole_pkg::DEPTH && $urandom_range(0, 3) == 0) growing = 1'b0;
      if (cnt == 0 && $urandom_range(0, 2) == 0) growing = 1'b1;
      r = $urandom_range(0, 99);
      if (r < (growing ? 55 : 10)) act = ole_pkg::ACT_APPEND;
      else if (r < 62) act = ole_pkg::ACT_DELETE;
      else if (r < 72) act = ole_pkg::ACT_COUNT;
      else if (r < 84) act = ole_pkg::ACT_DUMP_ALL;
      else if (r < 96) act = ole_pkg::ACT_DUMP_ALT;
      else act = 3'($urandom_range(5, 7));
      if (cnt > 0 && $urandom_range(0, 3) != 0) p = 5'($urandom_range(0, cnt - 1));
      else p = 5'($urandom());
      send(act, pick_value(), p);
    end
  endtask

  initial begin
    in_if.valid       = 1'b0;
    in_if.action      = ole_pkg::ACT_APPEND;
    in_if.item_value  = '0;
    in_if.position_in = '0;
    rst_n             = 1'b0;
    src_idle          = 0;
    dst_stall         = 0;
    hold_go           = 1'b0;
    growing           = 1'b1;
    repeat (9) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // empty-list corners and unknown actions
    send(ole_pkg::ACT_DUMP_ALL, '0, '0);
    send(ole_pkg::ACT_DUMP_ALT, '0, '0);
    send(ole_pkg::ACT_DELETE, '0, '0);
    send(ole_pkg::ACT_COUNT, '0, '0);
    send(3'd5, -32'sd1, 5'd31);
    send(3'd6, '0, '0);
    send(3'd7, 32'sh7fff_ffff, 5'd1);
    // single node: alternate dump shows nothing
    send(ole_pkg::ACT_APPEND, 32'sh8000_0000, '0);
    send(ole_pkg::ACT_DUMP_ALT, '0, '0);
    send(ole_pkg::ACT_APPEND, 32'sh7fff_ffff, '0);
    send(ole_pkg::ACT_APPEND, -32'sd1, '0);
    send(ole_pkg::ACT_APPEND, 32'sd0, '0);
    send(ole_pkg::ACT_APPEND, 32'sd1, '0);
    send(ole_pkg::ACT_COUNT, '0, '0);
    // index past the end
    send(ole_pkg::ACT_DELETE, '0, 5'd31);
    send(ole_pkg::ACT_DELETE, '0, 5'd5);
    send(ole_pkg::ACT_DUMP_ALL, '0, '0);
    send(ole_pkg::ACT_DUMP_ALT, '0, '0);
    // last, first, middle
    send(ole_pkg::ACT_DELETE, '0, 5'd4);
    send(ole_pkg::ACT_DELETE, '0, 5'd0);
    send(ole_pkg::ACT_DELETE, '0, 5'd1);
    send(ole_pkg::ACT_DUMP_ALL, '0, '0);

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin src_idle = 0;  dst_stall = 0;  hold_go = 1'b1; end
        1: begin src_idle = 69; dst_stall = 0;  end
        2: begin src_idle = 0;  dst_stall = 69; end
        default: begin src_idle = 17; dst_stall = 17; end
      endcase
      random_run(115);
    end
    in_if.valid = 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("ordered_list_engine test passed");
    else $display("ordered_list_engine test failed");
    $finish;
  end

endmodule
